// File: sv/nc1hwc2_to_nchw_remap_top_assert.svh
// Assertion macros for the NC1HWC2 to NCHW remap top level.
// They expect signals named clk and arst_n in the including module.
`ifndef NC1HWC2_TO_NCHW_REMAP_TOP_ASSERT_SVH
`define NC1HWC2_TO_NCHW_REMAP_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define NCRM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nc1hwc2_to_nchw_remap: same-cycle check failed");

// Consequence in the cycle after the condition.
`define NCRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nc1hwc2_to_nchw_remap: next-cycle check failed");

`endif

// File: sv/ncrm_pkg.sv
// Shared types, constants and helpers for the NC1HWC2 to NCHW remap block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package ncrm_pkg;

	// Default values of the top-level parameters.
	localparam int MAX_EXTENT_DEF = 1024;
	localparam int MAX_BLOCK_DEF = 32;
	localparam int MAX_PLANES_DEF = 256;
	localparam int ADDR_WIDTH_DEF = 32;

	// Fixed by the register and field widths.
	localparam int BATCH_LIMIT = 16;
	localparam int BATCH_W = 4;
	localparam int CHANNEL_W = 14;
	localparam int STRIDE_W = 21;
	localparam int PIX_W = 20;
	localparam int BPROD_W = BATCH_W + CHANNEL_W;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 21;
	localparam int QUEUE_DEPTH = 4;
	localparam int DEST_W = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BATCH_COUNT   = 3'd0,
		REG_PLANE_COUNT   = 3'd1,
		REG_ROW_COUNT     = 3'd2,
		REG_COLUMN_COUNT  = 3'd3,
		REG_BLOCK_SIZE    = 3'd4,
		REG_CHANNEL_COUNT = 3'd5,
		REG_PLANE_STRIDE  = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [4:0]  batch_count;
		logic [8:0]  plane_count;
		logic [10:0] row_count;
		logic [10:0] column_count;
		logic [5:0]  block_size;
		logic [13:0] channel_count;
		logic [20:0] plane_stride;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// A count of zero behaves as one, anything above the limit as the limit.
	function automatic logic [15:0] clamp_count(input logic [15:0] v, input logic [15:0] hi);
		logic [15:0] r;
		if (v == 16'd0) begin
			r = 16'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: sv/ncrm_queue.sv
// Short FIFO between the remap front end and the address pipeline.
// Uses ncrm_pkg for the status struct.
`timescale 1ns / 1ps

module ncrm_queue #(
	parameter int W = 8,
	parameter int DEPTH = ncrm_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  logic [W-1:0]         push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output logic [W-1:0]         pop_data,
	output ncrm_pkg::q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign stat.full  = !push_ready;
	assign stat.empty = !pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ncrm_front.sv
// Front end of the remap: source position counters, padding filter and tensor end flag.
// Uses ncrm_pkg for the configuration struct and the count clamp.
`timescale 1ns / 1ps

module ncrm_front #(
	parameter int MAX_EXTENT = ncrm_pkg::MAX_EXTENT_DEF,
	parameter int MAX_BLOCK = ncrm_pkg::MAX_BLOCK_DEF,
	parameter int MAX_PLANES = ncrm_pkg::MAX_PLANES_DEF,
	localparam int RW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1,
	localparam int CHW = (MAX_PLANES * MAX_BLOCK > 1) ? $clog2(MAX_PLANES * MAX_BLOCK) : 1,
	localparam int EW = ncrm_pkg::BATCH_W + 2 * RW + CHW + 8 + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ncrm_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [7:0]   element,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [EW-1:0]       out_data
);

	localparam int LW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int BW = ncrm_pkg::BATCH_W;
	localparam int CMPW = (CHW > ncrm_pkg::CHANNEL_W) ? CHW : ncrm_pkg::CHANNEL_W;

	logic [BW-1:0]  batch_q, b_c, b_n;
	logic [PW-1:0]  plane_q, p_c, p_n;
	logic [RW-1:0]  row_q, r_c, r_n;
	logic [RW-1:0]  col_q, c_c, c_n;
	logic [LW-1:0]  lane_q, l_c, l_n;
	logic [15:0]    nb, np, nr, nc, nl;
	logic           wrap_b, wrap_p, wrap_r, wrap_c, wrap_l;
	logic [CHW-1:0] chan_c;
	logic           keep;
	logic           last_c;
	logic           accept;

	assign nb = ncrm_pkg::clamp_count(16'(cfg.batch_count), 16'(ncrm_pkg::BATCH_LIMIT));
	assign np = ncrm_pkg::clamp_count(16'(cfg.plane_count), 16'(MAX_PLANES));
	assign nr = ncrm_pkg::clamp_count(16'(cfg.row_count), 16'(MAX_EXTENT));
	assign nc = ncrm_pkg::clamp_count(16'(cfg.column_count), 16'(MAX_EXTENT));
	assign nl = ncrm_pkg::clamp_count(16'(cfg.block_size), 16'(MAX_BLOCK));

	// A frame start restarts every counter before this element is placed.
	assign b_c = frame_start ? '0 : batch_q;
	assign p_c = frame_start ? '0 : plane_q;
	assign r_c = frame_start ? '0 : row_q;
	assign c_c = frame_start ? '0 : col_q;
	assign l_c = frame_start ? '0 : lane_q;

	assign wrap_b = (16'(b_c) + 16'd1 >= nb);
	assign wrap_p = (16'(p_c) + 16'd1 >= np);
	assign wrap_r = (16'(r_c) + 16'd1 >= nr);
	assign wrap_c = (16'(c_c) + 16'd1 >= nc);
	assign wrap_l = (16'(l_c) + 16'd1 >= nl);

	assign last_c = wrap_l && wrap_c && wrap_r && wrap_p && wrap_b;

	assign chan_c = CHW'(CHW'(p_c) * CHW'(nl) + CHW'(l_c));
	assign keep   = (CMPW'(chan_c) < CMPW'(cfg.channel_count));

	assign in_ready  = out_ready;
	assign out_valid = in_valid && keep;
	assign out_data  = {last_c, element, chan_c, c_c, r_c, b_c};
	assign accept    = in_valid && in_ready;

	// Nested odometer: lane innermost, batch outermost.
	always_comb begin
		l_n = wrap_l ? '0 : l_c + 1'b1;
		c_n = c_c;
		r_n = r_c;
		p_n = p_c;
		b_n = b_c;
		if (wrap_l) begin
			c_n = wrap_c ? '0 : c_c + 1'b1;
			if (wrap_c) begin
				r_n = wrap_r ? '0 : r_c + 1'b1;
				if (wrap_r) begin
					p_n = wrap_p ? '0 : p_c + 1'b1;
					if (wrap_p) begin
						b_n = wrap_b ? '0 : b_c + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= '0;
			plane_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			lane_q  <= '0;
		end else if (accept) begin
			batch_q <= b_n;
			plane_q <= p_n;
			row_q   <= r_n;
			col_q   <= c_n;
			lane_q  <= l_n;
		end
	end

endmodule

// File: sv/ncrm_back.sv
// Back end of the remap: four-stage destination address pipeline with output register.
// Uses ncrm_pkg for the configuration struct, widths and the count clamp.
`timescale 1ns / 1ps

module ncrm_back #(
	parameter int MAX_EXTENT = ncrm_pkg::MAX_EXTENT_DEF,
	parameter int MAX_BLOCK = ncrm_pkg::MAX_BLOCK_DEF,
	parameter int MAX_PLANES = ncrm_pkg::MAX_PLANES_DEF,
	parameter int ADDR_WIDTH = ncrm_pkg::ADDR_WIDTH_DEF,
	localparam int RW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1,
	localparam int CHW = (MAX_PLANES * MAX_BLOCK > 1) ? $clog2(MAX_PLANES * MAX_BLOCK) : 1,
	localparam int EW = ncrm_pkg::BATCH_W + 2 * RW + CHW + 8 + 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ncrm_pkg::cfg_t                     cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [EW-1:0]                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ncrm_pkg::DEST_W-1:0]        dest_index,
	output logic signed [7:0]                  value,
	output logic                               tensor_done
);

	localparam int BW = ncrm_pkg::BATCH_W;
	localparam int PXW = ncrm_pkg::PIX_W;
	localparam int BPW = ncrm_pkg::BPROD_W;
	localparam int TW = ((BPW > CHW) ? BPW : CHW) + 1;
	localparam int MW = TW + ncrm_pkg::STRIDE_W;
	localparam int AW = ADDR_WIDTH;

	logic [BW-1:0]     in_batch;
	logic [RW-1:0]     in_row;
	logic [RW-1:0]     in_col;
	logic [CHW-1:0]    in_chan;
	logic [7:0]        in_value;
	logic              in_last;
	logic [15:0]       nc;
	logic              adv;
	logic [MW-1:0]     prod_full;
	logic [AW-1:0]     dest_sum;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [BPW-1:0]    bprod_s1;
	logic [CHW-1:0]    chan_s1;
	logic [PXW-1:0]    pix_s1, pix_s2, pix_s3;
	logic [7:0]        value_s1, value_s2, value_s3, value_s4;
	logic              last_s1, last_s2, last_s3, last_s4;
	logic [TW-1:0]     tot_s2;
	logic [AW-1:0]     prod_s3;
	logic [ncrm_pkg::DEST_W-1:0] dest_s4;

	assign {in_last, in_value, in_chan, in_col, in_row, in_batch} = in_data;

	assign nc = ncrm_pkg::clamp_count(16'(cfg.column_count), 16'(MAX_EXTENT));

	// The whole pipe moves unless the output register holds a result nobody takes.
	assign adv      = !v_s4 || out_ready;
	assign in_ready = adv;

	assign prod_full = MW'(tot_s2) * MW'(cfg.plane_stride);
	assign dest_sum  = AW'(prod_s3 + AW'(pix_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: batch offset in channels and pixel offset within a plane.
			bprod_s1 <= BPW'(BPW'(in_batch) * BPW'(cfg.channel_count));
			pix_s1   <= PXW'(PXW'(in_row) * PXW'(nc) + PXW'(in_col));
			chan_s1  <= in_chan;
			value_s1 <= in_value;
			last_s1  <= in_last;
			// Stage 2: destination channel number.
			tot_s2   <= TW'(bprod_s1) + TW'(chan_s1);
			pix_s2   <= pix_s1;
			value_s2 <= value_s1;
			last_s2  <= last_s1;
			// Stage 3: channel base address, wrapped to the address width.
			prod_s3  <= AW'(prod_full);
			pix_s3   <= pix_s2;
			value_s3 <= value_s2;
			last_s3  <= last_s2;
			// Stage 4: output register.
			dest_s4  <= ncrm_pkg::DEST_W'(dest_sum);
			value_s4 <= value_s3;
			last_s4  <= last_s3;
		end
	end

	assign out_valid   = v_s4;
	assign dest_index  = dest_s4;
	assign value       = value_s4;
	assign tensor_done = last_s4;

endmodule

// File: sv/nc1hwc2_to_nchw_remap_top.sv
// NC1HWC2 to NCHW remap top level: config registers, front end, queue and address pipeline.
// Throughput is one element per cycle while the queue has room; a stalled output fills it.
// A taken element is queued at the accepting edge, then passes the four address registers.
// Padding lanes are taken by the front end and give no result.
// Reset clears all position counters and the queue and loads the register reset values.
`timescale 1ns / 1ps
`include "nc1hwc2_to_nchw_remap_top_assert.svh"

module nc1hwc2_to_nchw_remap_top #(
	parameter int MAX_EXTENT = ncrm_pkg::MAX_EXTENT_DEF,
	parameter int MAX_BLOCK = ncrm_pkg::MAX_BLOCK_DEF,
	parameter int MAX_PLANES = ncrm_pkg::MAX_PLANES_DEF,
	parameter int ADDR_WIDTH = ncrm_pkg::ADDR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel: one request writes one register.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ncrm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ncrm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Source elements.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] element
	input  logic                                s_tuser,  // [0] frame_start
	// Destination results.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [39:0]                         m_tdata,  // [31:0] dest_index, [39:32] value
	output logic                                m_tlast   // tensor_done
);

	localparam int RW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
	localparam int CHW = (MAX_PLANES * MAX_BLOCK > 1) ? $clog2(MAX_PLANES * MAX_BLOCK) : 1;
	localparam int EW = ncrm_pkg::BATCH_W + 2 * RW + CHW + 8 + 1;

	ncrm_pkg::cfg_t    cfg_q;
	ncrm_pkg::q_stat_t q_stat;

	logic              f_valid;
	logic              f_ready;
	logic [EW-1:0]     f_data;
	logic              b_valid;
	logic              b_ready;
	logic [EW-1:0]     b_data;
	logic [ncrm_pkg::DEST_W-1:0] dest_index;
	logic signed [7:0] value;

	// Registers may be written at any time; the user, not the block, keeps it idle when it matters.
	// Writes to an index beyond the register list complete and are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.batch_count   <= 5'd1;
			cfg_q.plane_count   <= 9'd1;
			cfg_q.row_count     <= 11'd1;
			cfg_q.column_count  <= 11'd1;
			cfg_q.block_size    <= 6'd16;
			cfg_q.channel_count <= 14'd16;
			cfg_q.plane_stride  <= 21'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ncrm_pkg::REG_BATCH_COUNT:   cfg_q.batch_count   <= cfg_data[4:0];
				ncrm_pkg::REG_PLANE_COUNT:   cfg_q.plane_count   <= cfg_data[8:0];
				ncrm_pkg::REG_ROW_COUNT:     cfg_q.row_count     <= cfg_data[10:0];
				ncrm_pkg::REG_COLUMN_COUNT:  cfg_q.column_count  <= cfg_data[10:0];
				ncrm_pkg::REG_BLOCK_SIZE:    cfg_q.block_size    <= cfg_data[5:0];
				ncrm_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[13:0];
				ncrm_pkg::REG_PLANE_STRIDE:  cfg_q.plane_stride  <= cfg_data[20:0];
				default: begin
				end
			endcase
		end
	end

	// The front end tracks the source position, flags the last element of a
	// tensor and drops padding lanes before they reach the queue.
	ncrm_front #(
		.MAX_EXTENT (MAX_EXTENT),
		.MAX_BLOCK  (MAX_BLOCK),
		.MAX_PLANES (MAX_PLANES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.element     (s_tdata),
		.frame_start (s_tuser),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.out_data    (f_data)
	);

	// The queue lets the front keep taking elements while the output is stalled, until it is full.
	ncrm_queue #(
		.W     (EW),
		.DEPTH (ncrm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data),
		.stat       (q_stat)
	);

	// The back end turns positions into the NCHW destination index.
	ncrm_back #(
		.MAX_EXTENT (MAX_EXTENT),
		.MAX_BLOCK  (MAX_BLOCK),
		.MAX_PLANES (MAX_PLANES),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (b_valid),
		.in_ready    (b_ready),
		.in_data     (b_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.dest_index  (dest_index),
		.value       (value),
		.tensor_done (m_tlast)
	);

	assign m_tdata = {value, dest_index};

	// A full queue can never be empty at the same time.
	`NCRM_ASSERT_SAME(a_queue_full_not_empty, q_stat.full, !q_stat.empty)
	// A request pushed into the queue leaves it holding at least one entry.
	`NCRM_ASSERT_NEXT(a_push_fills_queue, f_valid && f_ready, !q_stat.empty)

endmodule

// File: dv/nc1hwc2_to_nchw_remap_top_tb.sv
// Self-checking testbench for the NC1HWC2 to NCHW remap top level.
// It streams source elements, predicts each destination index in its own model and checks
// every result; it depends on ncrm_pkg and nc1hwc2_to_nchw_remap_top.
`timescale 1ns / 1ps

module nc1hwc2_to_nchw_remap_top_tb;

	typedef logic [ncrm_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// Index that names no register; a write to it must leave every register alone.
	localparam logic [ncrm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	// Cycles to wait after the last expected result. The pipeline is four deep, and a
	// few spare cycles let it settle before the registers change.
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [ncrm_pkg::DEST_W-1:0] dest_index;
		logic [7:0]                  value;
		logic                        tensor_done;
	} remap_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [ncrm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ncrm_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;   // [7:0] element
	logic                             s_tuser;   // [0] frame_start
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [39:0]                      m_tdata;   // [31:0] dest_index, [39:32] value
	logic                             m_tlast;   // tensor_done

	nc1hwc2_to_nchw_remap_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Percentages of cycles in which the source holds back a request or the sink stalls.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int error_count = 0;

	// Results still owed by the block, oldest first.
	remap_result_t pending_results[$];

	// Our copy of the registers and the source position counters.
	ncrm_pkg::cfg_t  tensor_cfg;
	longint unsigned batch_pos, plane_pos, row_pos, column_pos, lane_pos;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// A count of zero acts as one and anything past the limit as the limit.
	function automatic longint unsigned clamp_extent(input longint unsigned raw,
			input longint unsigned hi);
		if (raw == 0) begin
			return 1;
		end
		return (raw > hi) ? hi : raw;
	endfunction

	// Steps a position counter; it wraps, and carries, once pos+1 reaches the count.
	function automatic bit step_wraps(inout longint unsigned pos, input longint unsigned cnt);
		if (pos + 1 >= cnt) begin
			pos = 0;
			return 1'b1;
		end
		pos++;
		return 1'b0;
	endfunction

	function automatic void reset_remap_model();
		tensor_cfg.batch_count = 5'd1;
		tensor_cfg.plane_count = 9'd1;
		tensor_cfg.row_count = 11'd1;
		tensor_cfg.column_count = 11'd1;
		tensor_cfg.block_size = 6'd16;
		tensor_cfg.channel_count = 14'd16;
		tensor_cfg.plane_stride = 21'd1;
		batch_pos = 0;
		plane_pos = 0;
		row_pos = 0;
		column_pos = 0;
		lane_pos = 0;
	endfunction

	// Works out the destination of one accepted element and queues it unless the lane
	// is padding. The counters then advance lane first, batch last.
	function automatic void predict_destination(input logic [7:0] elem, input logic frame_start);
		longint unsigned nb, np, nr, nc, nl, chans, stride;
		longint unsigned base, pix, chan, dest;
		remap_result_t   res;
		bit              carry;
		nb = clamp_extent(tensor_cfg.batch_count, ncrm_pkg::BATCH_LIMIT);
		np = clamp_extent(tensor_cfg.plane_count, ncrm_pkg::MAX_PLANES_DEF);
		nr = clamp_extent(tensor_cfg.row_count, ncrm_pkg::MAX_EXTENT_DEF);
		nc = clamp_extent(tensor_cfg.column_count, ncrm_pkg::MAX_EXTENT_DEF);
		nl = clamp_extent(tensor_cfg.block_size, ncrm_pkg::MAX_BLOCK_DEF);
		chans = tensor_cfg.channel_count;
		stride = tensor_cfg.plane_stride;
		if (frame_start) begin
			batch_pos = 0;
			plane_pos = 0;
			row_pos = 0;
			column_pos = 0;
			lane_pos = 0;
		end
		base = ((batch_pos * chans + plane_pos * nl) * stride) & 64'hFFFF_FFFF;
		pix = (row_pos * nc + column_pos) & 64'hF_FFFF;
		chan = plane_pos * nl + lane_pos;
		if (chan < chans) begin
			dest = (base + lane_pos * stride + pix) & 64'hFFFF_FFFF;
			res.dest_index = dest[ncrm_pkg::DEST_W-1:0];
			res.value = elem;
			res.tensor_done = (lane_pos + 1 >= nl) && (column_pos + 1 >= nc) &&
				(row_pos + 1 >= nr) && (plane_pos + 1 >= np) && (batch_pos + 1 >= nb);
			pending_results = {pending_results, res};
		end
		carry = step_wraps(lane_pos, nl);
		if (carry) carry = step_wraps(column_pos, nc);
		if (carry) carry = step_wraps(row_pos, nr);
		if (carry) carry = step_wraps(plane_pos, np);
		if (carry) carry = step_wraps(batch_pos, nb);
	endfunction

	// Result side: the sink stalls at random, and every accepted result is checked
	// field by field against the oldest prediction.
	always @(posedge clk) begin : result_sink
		remap_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %08h with no element waiting for it",
					m_tdata[31:0]));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.dest_index) begin
					report_mismatch($sformatf("dest_index %08h, expected %08h",
						m_tdata[31:0], want.dest_index));
				end
				if (m_tdata[39:32] !== want.value) begin
					report_mismatch($sformatf("value %02h, expected %02h (dest %08h)",
						m_tdata[39:32], want.value, want.dest_index));
				end
				if (m_tlast !== want.tensor_done) begin
					report_mismatch($sformatf("tensor_done %b, expected %b (dest %08h)",
						m_tlast, want.tensor_done, want.dest_index));
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Offers one element, holding the request until the block takes it. The valid is
	// left high afterwards so that back-to-back elements follow without a gap.
	task automatic send_element(input logic [7:0] elem, input logic frame_start);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= elem;
		s_tuser <= frame_start;
		do @(posedge clk); while (!s_tready);
		predict_destination(elem, frame_start);
	endtask

	// Stops the source and waits until every owed result has come back and the
	// pipeline has had a few cycles to settle.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write request; valid stays high for the caller to lower.
	task automatic write_reg(input logic [ncrm_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ncrm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ncrm_pkg::REG_BATCH_COUNT:   tensor_cfg.batch_count = data[4:0];
			ncrm_pkg::REG_PLANE_COUNT:   tensor_cfg.plane_count = data[8:0];
			ncrm_pkg::REG_ROW_COUNT:     tensor_cfg.row_count = data[10:0];
			ncrm_pkg::REG_COLUMN_COUNT:  tensor_cfg.column_count = data[10:0];
			ncrm_pkg::REG_BLOCK_SIZE:    tensor_cfg.block_size = data[5:0];
			ncrm_pkg::REG_CHANNEL_COUNT: tensor_cfg.channel_count = data[13:0];
			ncrm_pkg::REG_PLANE_STRIDE:  tensor_cfg.plane_stride = data[20:0];
			default: ;
		endcase
	endtask

	// Reprograms the whole shape once the block is idle. The raw values go out as
	// given, so zero and oversize counts reach the block unclamped. A stray write to
	// the unused index comes first and must change nothing.
	task automatic apply_tensor_shape(input cfg_word_t batches,
			input cfg_word_t planes, input cfg_word_t rows,
			input cfg_word_t columns, input cfg_word_t block,
			input cfg_word_t channels, input cfg_word_t stride);
		drain_results();
		write_reg(REG_UNUSED, cfg_word_t'($urandom));
		write_reg(ncrm_pkg::REG_BATCH_COUNT, batches);
		write_reg(ncrm_pkg::REG_PLANE_COUNT, planes);
		write_reg(ncrm_pkg::REG_ROW_COUNT, rows);
		write_reg(ncrm_pkg::REG_COLUMN_COUNT, columns);
		write_reg(ncrm_pkg::REG_BLOCK_SIZE, block);
		write_reg(ncrm_pkg::REG_CHANNEL_COUNT, channels);
		write_reg(ncrm_pkg::REG_PLANE_STRIDE, stride);
		cfg_valid <= 1'b0;
	endtask

	// Reset values: sixteen lanes of one pixel, all kept, with the value extremes.
	task automatic test_reset_defaults();
		send_element(8'h7F, 1'b1);
		send_element(8'h80, 1'b0);
		send_element(8'h00, 1'b0);
		send_element(8'hFF, 1'b0);
	endtask

	// Two planes of four lanes with six real channels: the top two lanes are padding,
	// and since the last source element is padding this tensor never shows done.
	task automatic test_padding_lanes();
		apply_tensor_shape(1, 2, 1, 1, 4, 6, 5);
		for (int i = 0; i < 8; i++) begin
			send_element(8'($urandom), i == 0);
		end
	endtask

	// Every count written as zero acts as one; a channel count of zero drops everything.
	task automatic test_zero_counts();
		apply_tensor_shape(0, 0, 0, 0, 0, 0, 0);
		send_element(8'h55, 1'b1);
		send_element(8'hAA, 1'b0);
	endtask

	// One element per batch with a channel count of 8191 and the largest stride, so the batch
	// offset runs far past 32 bits and the index has to wrap. The batch count of 31
	// is clamped to sixteen.
	task automatic test_address_wraparound();
		apply_tensor_shape(31, 1, 1, 1, 1, 8191, 21'h1F_FFFF);
		for (int i = 0; i < 5; i++) begin
			send_element(8'($urandom), i == 0);
		end
	endtask

	// All extents at their top (oversize raw values clamp), then the block size is
	// cut below the current lane while the tensor is under way: the lane counter has
	// to wrap on the very next element instead of counting on.
	task automatic test_count_lowered_midtensor();
		apply_tensor_shape(31, 511, 2047, 2047, 63, 16383, 21'h1F_FFFF);
		for (int i = 0; i < 4; i++) begin
			send_element(8'($urandom), i == 0);
		end
		apply_tensor_shape(16, 256, 1024, 1024, 2, 8192, 21'h1F_FFFF);
		send_element(8'($urandom), 1'b0);
		send_element(8'($urandom), 1'b0);
	endtask

	// Random traffic under one idling pattern. Shapes are small so that many tensors
	// complete; most tensors are whole and start with a frame start, a few are cut
	// short, and now and then a frame start goes missing or turns up mid-tensor.
	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int budget);
		int              sent;
		int              cut;
		cfg_word_t       raw_b, raw_p, raw_r, raw_c, raw_l, raw_ch, raw_st;
		longint unsigned elems, lanes_total, pixels;
		logic            frame_start;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		sent = 0;
		while (sent < budget) begin
			do begin
				raw_b = cfg_word_t'($urandom_range(0, 3));
				raw_p = cfg_word_t'($urandom_range(1, 3));
				raw_r = cfg_word_t'($urandom_range(1, 3));
				raw_c = cfg_word_t'($urandom_range(0, 4));
				raw_l = ($urandom_range(7) == 0) ? cfg_word_t'(40) :
					cfg_word_t'($urandom_range(1, 8));
				elems = clamp_extent(raw_b, ncrm_pkg::BATCH_LIMIT) *
					clamp_extent(raw_p, ncrm_pkg::MAX_PLANES_DEF) *
					clamp_extent(raw_r, ncrm_pkg::MAX_EXTENT_DEF) *
					clamp_extent(raw_c, ncrm_pkg::MAX_EXTENT_DEF) *
					clamp_extent(raw_l, ncrm_pkg::MAX_BLOCK_DEF);
			end while (elems > 96);
			lanes_total = clamp_extent(raw_p, ncrm_pkg::MAX_PLANES_DEF) *
				clamp_extent(raw_l, ncrm_pkg::MAX_BLOCK_DEF);
			pixels = clamp_extent(raw_r, ncrm_pkg::MAX_EXTENT_DEF) *
				clamp_extent(raw_c, ncrm_pkg::MAX_EXTENT_DEF);
			case ($urandom_range(3))
				0: raw_ch = cfg_word_t'($urandom_range(0, 16383));
				1, 2: raw_ch = cfg_word_t'($urandom_range(1, int'(lanes_total)));
				default: raw_ch = cfg_word_t'(lanes_total);
			endcase
			case ($urandom_range(3))
				0: raw_st = cfg_word_t'(pixels);
				1: raw_st = cfg_word_t'($urandom_range(0, 21'h1F_FFFF));
				2: raw_st = 21'h1F_FFFF;
				default: raw_st = cfg_word_t'($urandom_range(0, 40));
			endcase
			apply_tensor_shape(raw_b, raw_p, raw_r, raw_c, raw_l, raw_ch, raw_st);
			repeat ($urandom_range(1, 3)) begin
				cut = int'(elems);
				if ($urandom_range(9) == 0) cut = int'($urandom_range(1, cut));
				for (int i = 0; i < cut && sent < budget; i++) begin
					frame_start = (i == 0);
					if ($urandom_range(29) == 0) frame_start = !frame_start;
					send_element(8'($urandom), frame_start);
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		reset_remap_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_padding_lanes();
		test_zero_counts();
		test_address_wraparound();
		test_count_lowered_midtensor();

		// Idling patterns: none, a slow source, a slow sink, then both a little.
		test_random_traffic(0, 0, 480);
		test_random_traffic(65, 0, 480);
		test_random_traffic(0, 65, 480);
		test_random_traffic(19, 19, 480);

		drain_results();
		if (error_count == 0) begin
			$display("nc1hwc2_to_nchw_remap_top_tb: PASS");
		end else begin
			$display("nc1hwc2_to_nchw_remap_top_tb: FAIL");
		end
		$finish;
	end

	// Far beyond the slowest correct run; a hung handshake ends here.
	initial begin
		#2_000_000;
		$display("ERROR: timed out with %0d results still owed", pending_results.size());
		$display("nc1hwc2_to_nchw_remap_top_tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/ncrm_pkg.sv
sv/ncrm_queue.sv
sv/ncrm_front.sv
sv/ncrm_back.sv
sv/nc1hwc2_to_nchw_remap_top.sv
dv/nc1hwc2_to_nchw_remap_top_tb.sv
